// File: rtl/csvfs_pkg.sv
// Shared types, character codes and helpers for the CSV field splitter.
package csvfs_pkg;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_FIELD = 2'd1;
    localparam logic [1:0] KIND_ROW   = 2'd2;

    localparam logic [7:0] FIELD_MAX  = 8'd255;

    // controller -> datapath
    typedef struct packed {
        logic accept;        // latch the input beat
        logic exec;          // perform one step of the current unit
        logic sel_cr;        // current unit is content of a held CR
        logic sel_end;       // current unit is a line end
        logic release_last;  // move the pending result out, marked last
    } csvfs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_end;        // live input is end of stream
        logic in_cr;         // live input byte is CR
        logic in_lf;         // live input byte is LF
        logic cr_held;       // a CR is waiting from the previous beat
        logic byte_cr;       // latched byte is CR
        logic step_ready;    // result slot can take this step's result
        logic step_done;     // this step finishes the current unit
        logic pend_valid;    // a result waits in the pending slot
        logic out_free;      // output register can take a result
    } csvfs_status_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
    endfunction

endpackage

// File: rtl/csvfs_ctrl.sv
// Sequencer that walks each input beat through its content and line-end units.
module csvfs_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  csvfs_pkg::csvfs_status_t st,
    output csvfs_pkg::csvfs_cmd_t    cmd
);
    import csvfs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CR   = 5'b00010,
        S_BYTE = 5'b00100,
        S_END  = 5'b01000,
        S_LAST = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   in_proc;

    assign s_ready = (state_reg == S_IDLE);
    assign in_proc = (state_reg == S_CR) || (state_reg == S_BYTE) || (state_reg == S_END);

    always_comb
    begin
        cmd.accept       = s_ready && s_valid;
        cmd.exec         = in_proc && st.step_ready;
        cmd.sel_cr       = (state_reg == S_CR);
        cmd.sel_end      = (state_reg == S_END);
        cmd.release_last = (state_reg == S_LAST) && st.pend_valid && st.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_valid)
                begin
                    if (st.op_end)
                        state_next = S_END;
                    else if (st.cr_held && st.in_lf)
                        state_next = S_END;
                    else if (st.cr_held)
                        state_next = S_CR;
                    else if (st.in_cr)
                        state_next = S_IDLE;   // CR just held, no results yet
                    else if (st.in_lf)
                        state_next = S_END;
                    else
                        state_next = S_BYTE;
                end
            end
            S_CR:
            begin
                if (cmd.exec && st.step_done)
                    state_next = st.byte_cr ? S_LAST : S_BYTE;
            end
            S_BYTE, S_END:
            begin
                if (cmd.exec && st.step_done)
                    state_next = S_LAST;
            end
            S_LAST:
            begin
                if (!st.pend_valid || st.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/csvfs_datapath.sv
// Parser state, whitespace hold buffer, pending result slot and output register.
module csvfs_datapath
#(
    parameter int SPACE_HOLD_DEPTH = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_op,
    input  logic [7:0]               in_byte,
    input  csvfs_pkg::csvfs_cmd_t    cmd,
    output csvfs_pkg::csvfs_status_t st,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               out_kind,
    output logic [7:0]               out_byte,
    output logic [7:0]               out_field,
    output logic                     out_ovf,
    output logic                     out_last
);
    import csvfs_pkg::*;

    localparam int CNT_W = $clog2(SPACE_HOLD_DEPTH + 1);
    localparam int IDX_W = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;

    typedef enum logic [5:0] {
        M_START  = 6'b000001,
        M_LEAD   = 6'b000010,
        M_BODY   = 6'b000100,
        M_QUOTED = 6'b001000,
        M_QSEEN  = 6'b010000,
        M_AFTER  = 6'b100000
    } mode_t;

    mode_t            mode_reg;
    logic             line_started_reg;
    logic             cr_held_reg;
    logic [7:0]       byte_reg;
    logic [7:0]       held_reg [SPACE_HOLD_DEPTH];
    logic [CNT_W-1:0] held_count_reg;
    logic [7:0]       field_counter_reg;

    logic             pend_valid_reg;
    logic             pend_valid_next;
    logic [1:0]       pend_kind_reg;
    logic [7:0]       pend_byte_reg;
    logic [7:0]       pend_field_reg;
    logic             pend_ovf_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_field_reg;
    logic             out_ovf_reg;
    logic             out_last_reg;

    // one step of the current unit
    logic             step_emit;
    logic [1:0]       step_kind;
    logic [7:0]       step_byte;
    logic             step_ovf;
    logic             step_done;
    mode_t            mode_next;
    logic             line_started_next;
    logic [CNT_W-1:0] held_count_next;
    logic [7:0]       field_counter_next;
    logic             hold_shift;
    logic             hold_wr;
    logic [IDX_W-1:0] hold_idx;

    logic [7:0]       ch;
    logic             ch_ws;
    logic             hold_full;
    logic [7:0]       field_inc;
    logic             out_free;

    assign ch        = cmd.sel_cr ? CHAR_CR : byte_reg;
    assign ch_ws     = is_ws(ch);
    assign hold_full = (held_count_reg == CNT_W'(SPACE_HOLD_DEPTH));
    assign field_inc = (field_counter_reg == FIELD_MAX) ? FIELD_MAX
                                                        : field_counter_reg + 8'd1;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        step_emit          = 1'b0;
        step_kind          = KIND_DATA;
        step_byte          = 8'd0;
        step_ovf           = 1'b0;
        step_done          = 1'b1;
        mode_next          = mode_reg;
        line_started_next  = line_started_reg;
        held_count_next    = held_count_reg;
        field_counter_next = field_counter_reg;
        hold_shift         = 1'b0;
        hold_wr            = 1'b0;
        hold_idx           = hold_full ? IDX_W'(SPACE_HOLD_DEPTH - 1)
                                       : held_count_reg[IDX_W-1:0];

        if (cmd.sel_end)
        begin
            step_emit          = line_started_reg;
            step_kind          = KIND_ROW;
            field_counter_next = 8'd0;
            held_count_next    = '0;
            mode_next          = M_START;
            line_started_next  = 1'b0;
        end
        else
        begin
            line_started_next = 1'b1;
            if (ch == CHAR_COMMA && mode_reg != M_QUOTED)
            begin
                // end of field from every mode outside a quoted run
                step_emit          = 1'b1;
                step_kind          = KIND_FIELD;
                field_counter_next = field_inc;
                held_count_next    = '0;
                mode_next          = M_START;
            end
            else
            begin
                case (mode_reg)
                    M_START:
                    begin
                        if (ch == CHAR_QUOTE)
                            mode_next = M_QUOTED;
                        else if (ch_ws)
                            mode_next = M_LEAD;
                        else
                        begin
                            step_emit = 1'b1;
                            step_byte = ch;
                            mode_next = M_BODY;
                        end
                    end
                    M_LEAD:
                    begin
                        if (!ch_ws)
                        begin
                            step_emit = 1'b1;
                            step_byte = ch;
                            mode_next = M_BODY;
                        end
                    end
                    M_BODY:
                    begin
                        if (ch_ws)
                        begin
                            hold_wr = 1'b1;
                            if (hold_full)
                            begin
                                // oldest held byte goes out untrimmed
                                step_emit  = 1'b1;
                                step_byte  = held_reg[0];
                                step_ovf   = 1'b1;
                                hold_shift = 1'b1;
                            end
                            else
                                held_count_next = held_count_reg + CNT_W'(1);
                        end
                        else if (held_count_reg != '0)
                        begin
                            // flush one held byte per cycle while the result slot can take it, then the byte itself
                            step_emit       = 1'b1;
                            step_byte       = held_reg[0];
                            hold_shift      = 1'b1;
                            held_count_next = held_count_reg - CNT_W'(1);
                            step_done       = 1'b0;
                        end
                        else
                        begin
                            step_emit = 1'b1;
                            step_byte = ch;
                        end
                    end
                    M_QUOTED:
                    begin
                        if (ch == CHAR_QUOTE)
                            mode_next = M_QSEEN;
                        else
                        begin
                            step_emit = 1'b1;
                            step_byte = ch;
                        end
                    end
                    M_QSEEN:
                    begin
                        if (ch == CHAR_QUOTE)
                        begin
                            step_emit = 1'b1;
                            step_byte = ch;
                            mode_next = M_QUOTED;
                        end
                        else
                            mode_next = M_AFTER;
                    end
                    M_AFTER:
                    begin
                        mode_next = M_AFTER;
                    end
                    default:
                        mode_next = M_START;
                endcase
            end
        end
    end

    always_comb
    begin
        st.op_end     = in_op;
        st.in_cr      = (in_byte == CHAR_CR);
        st.in_lf      = (in_byte == CHAR_LF);
        st.cr_held    = cr_held_reg;
        st.byte_cr    = (byte_reg == CHAR_CR);
        st.step_ready = !step_emit || !pend_valid_reg || out_free;
        st.step_done  = step_done;
        st.pend_valid = pend_valid_reg;
        st.out_free   = out_free;
    end

    // parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= M_START;
            line_started_reg  <= 1'b0;
            cr_held_reg       <= 1'b0;
            held_count_reg    <= '0;
            field_counter_reg <= 8'd0;
        end
        else
        begin
            if (cmd.accept)
                cr_held_reg <= !in_op && (in_byte == CHAR_CR);
            if (cmd.exec)
            begin
                mode_reg          <= mode_next;
                line_started_reg  <= line_started_next;
                held_count_reg    <= held_count_next;
                field_counter_reg <= field_counter_next;
            end
        end
    end

    // input byte and whitespace hold buffer
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            byte_reg <= in_byte;
        if (cmd.exec)
        begin
            if (hold_shift)
            begin
                for (int i = 0; i < SPACE_HOLD_DEPTH - 1; i++)
                    held_reg[i] <= held_reg[i + 1];
            end
            if (hold_wr)
                held_reg[hold_idx] <= ch;
        end
    end

    // pending slot and output register valid flags
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (cmd.exec && step_emit)
        begin
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
                out_valid_next = 1'b1;
        end
        if (cmd.release_last)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payloads; the newest result waits until the next one or the end
    // of the beat decides whether it is last
    always_ff @(posedge clk)
    begin
        if (cmd.exec && step_emit)
        begin
            pend_kind_reg  <= step_kind;
            pend_byte_reg  <= step_byte;
            pend_field_reg <= field_counter_reg;
            pend_ovf_reg   <= step_ovf;
        end
        if ((cmd.exec && step_emit && pend_valid_reg) || cmd.release_last)
        begin
            out_kind_reg  <= pend_kind_reg;
            out_byte_reg  <= pend_byte_reg;
            out_field_reg <= pend_field_reg;
            out_ovf_reg   <= pend_ovf_reg;
            out_last_reg  <= cmd.release_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_field = out_field_reg;
    assign out_ovf   = out_ovf_reg;
    assign out_last  = out_last_reg;

endmodule

// File: rtl/csv_field_splitter.sv
// Top level of the streaming CSV field and row splitter.
// Each input beat is one text byte (tuser = 0) or an end-of-stream mark
// (tuser = 1); the block returns data bytes, end-of-field and end-of-row
// beats, with tlast on the final beat caused by that input. Items are taken
// one at a time: a beat is accepted, then the sequencer runs one step per
// result it causes (one step even when there is none) and then hands the
// final result to the output register. A CR that is only held back is just
// accepted, with no step. A beat that flushes a full whitespace buffer of
// SPACE_HOLD_DEPTH bytes runs one step per held byte before its own byte.
// The output register lets the next beat be accepted while the last result
// still waits for m_axis_tready.
module csv_field_splitter
#(
    parameter int SPACE_HOLD_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] byte_out, [15:8] field_number
    output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] space_overflow
    output logic        m_axis_tlast
);
    import csvfs_pkg::*;

    csvfs_cmd_t    cmd;
    csvfs_status_t st;
    logic [1:0]    out_kind;
    logic [7:0]    out_byte;
    logic [7:0]    out_field;
    logic          out_ovf;

    csvfs_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .st      (st),
        .cmd     (cmd)
    );

    csvfs_datapath
    #(
        .SPACE_HOLD_DEPTH (SPACE_HOLD_DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_op     (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .cmd       (cmd),
        .st        (st),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .out_field (out_field),
        .out_ovf   (out_ovf),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_field, out_byte};
    assign m_axis_tuser = {out_ovf, out_kind};

endmodule
